// File: rtl/core/pidc_pkg.sv
// Shared types, widths and register indexes for the positional PID block.
// Used by the modules under rtl/core other than pidc_fifo; depends on nothing.
`default_nettype none

package pidc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int GAIN_W   = 24;
    localparam int LIM_W    = 31;
    localparam int ACC_W    = 32;
    localparam int PROD_W   = GAIN_W + ERR_W;
    localparam int DPROD_W  = GAIN_W + DIFF_W;
    localparam int SUM_W    = 44;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM  = 3'd4;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [LIM_W-1:0]  integral_limit;
        logic        [LIM_W-1:0]  output_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
    } t_work;

    // Symmetric clamp of a wide exact value; the result always fits 32 bits.
    function automatic logic signed [ACC_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] x,
        input logic        [LIM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] lim_s;
        logic signed [SUM_W-1:0] res;
        lim_s = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        if (x > lim_s) begin
            res = lim_s;
        end else if (x < -lim_s) begin
            res = -lim_s;
        end else begin
            res = x;
        end
        return res[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pidc_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic; no package dependency. DEPTH must be a power of two, at least 2.
`default_nettype none

module pidc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic                            o_empty,
    output logic [WIDTH-1:0]                o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign wr_fire = i_push && !o_full;
    assign rd_fire = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pidc_front.sv
// Front end: takes samples, forms the error and its change since the last sample.
// Depends on pidc_pkg.
`default_nettype none

module pidc_front
    import pidc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic signed [SAMPLE_W-1:0]  i_target,
    input  wire logic signed [SAMPLE_W-1:0]  i_measured,
    output t_work                            o_work
);

    logic signed [ERR_W-1:0] r_prev_error;
    logic signed [ERR_W-1:0] err;

    assign err         = ERR_W'(i_target) - ERR_W'(i_measured);
    assign o_work.err  = err;
    assign o_work.diff = DIFF_W'(err) - DIFF_W'(r_prev_error);

    // The previous error only moves with accepted samples.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
        end else if (i_accept) begin
            r_prev_error <= err;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pidc_back.sv
// Back end: three-stage datapath with the integrator loop and both clamps.
// Depends on pidc_pkg; issues only when the result queue has room reserved.
`default_nettype none

module pidc_back
    import pidc_pkg::*;
#(
    parameter int OUT_DEPTH = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  t_cfg                                    i_cfg,
    input  wire logic                               i_work_empty,
    input  t_work                                   i_work,
    output logic                                    o_work_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]     i_out_count,
    output logic                                    o_res_push,
    output logic signed [ACC_W-1:0]                 o_res_drive
);

    localparam int PEND_W = $clog2(OUT_DEPTH+1) + 1;

    logic                        r_s1_v;
    logic                        r_s2_v;
    logic                        r_s3_v;
    logic signed [PROD_W-1:0]    r_p_prod;
    logic signed [PROD_W-1:0]    r_i_prod;
    logic signed [DPROD_W-1:0]   r_d_prod;
    logic signed [ACC_W-1:0]     r_integ;
    logic signed [SUM_W-1:0]     r_pd;
    logic signed [ACC_W-1:0]     r_drive;
    logic signed [ACC_W-1:0]     n_integ;
    logic [PEND_W-1:0]           pending;
    logic                        issue;

    // Every item in flight already owns a slot in the result queue.
    assign pending = PEND_W'(i_out_count) + PEND_W'(r_s1_v) + PEND_W'(r_s2_v)
                   + PEND_W'(r_s3_v);
    assign issue      = !i_work_empty && (pending < PEND_W'(OUT_DEPTH));
    assign o_work_pop = issue;

    assign n_integ = clamp_sym(SUM_W'(r_integ) + SUM_W'(r_i_prod),
                               i_cfg.integral_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_integ <= '0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (r_s1_v) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_prod <= i_cfg.gain_p * i_work.err;
            r_i_prod <= i_cfg.gain_i * i_work.err;
            r_d_prod <= i_cfg.gain_d * i_work.diff;
        end
        if (r_s1_v) begin
            r_pd <= SUM_W'(r_p_prod) + SUM_W'(r_d_prod);
        end
        if (r_s2_v) begin
            r_drive <= clamp_sym(r_pd + SUM_W'(r_integ), i_cfg.output_limit);
        end
    end

    assign o_res_push  = r_s3_v;
    assign o_res_drive = r_drive;

endmodule

`default_nettype wire

// File: rtl/core/pid_positional_clamped_top.sv
// Positional PID controller with integrator and drive clamps, one drive per sample.
// Path: work queue, product, sum-and-integrator and clamp stages, result queue.
// One sample per cycle if results drain, limited by integrator add-and-clamp loop.
// Reset (synchronous, active low) clears the gains, limits, integrator and
// previous error, and empties both queues.
// Depends on pidc_pkg, pidc_front, pidc_fifo and pidc_back.
`default_nettype none

module pid_positional_clamped_top
    import pidc_pkg::*;
#(
    parameter int WORK_DEPTH = 2,
    parameter int OUT_DEPTH  = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic signed [SAMPLE_W-1:0]  i_target,
    input  wire logic signed [SAMPLE_W-1:0]  i_measured,
    output logic                             empty,
    input  wire logic                        pop,
    output logic signed [ACC_W-1:0]          o_drive,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [LIM_W-1:0]            i_cfg_wdata
);

    t_cfg                               r_cfg;
    t_work                              front_work;
    t_work                              back_work;
    logic                               accept;
    logic                               work_empty;
    logic                               work_pop;
    logic                               res_push;
    logic signed [ACC_W-1:0]            res_drive;
    logic [$clog2(OUT_DEPTH+1)-1:0]     out_count;

    // Configuration registers, read directly by the datapath. Writes must be made
    // only while idle; the block does not enforce this. Unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_GAIN_P:  r_cfg.gain_p         <= i_cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:  r_cfg.gain_i         <= i_cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:  r_cfg.gain_d         <= i_cfg_wdata[GAIN_W-1:0];
                REG_INT_LIM: r_cfg.integral_limit <= i_cfg_wdata;
                REG_OUT_LIM: r_cfg.output_limit   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A sample is taken whenever the work queue has room for its transfer.
    assign accept = push && !full;

    // The front end holds the previous error, so the derivative difference is
    // settled in the order samples arrive.
    pidc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_target   (i_target),
        .i_measured (i_measured),
        .o_work     (front_work)
    );

    // The work queue decouples sample intake from the arithmetic pipeline.
    pidc_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (WORK_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (full),
        .i_pop   (work_pop),
        .o_empty (work_empty),
        .o_data  (back_work),
        .o_count ()
    );

    // The back end multiplies, updates the integrator and clamps. It only
    // issues an item when a result slot is guaranteed, so it never stalls
    // mid-pipeline and the integrator advances exactly once per item.
    pidc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_empty (work_empty),
        .i_work       (back_work),
        .o_work_pop   (work_pop),
        .i_out_count  (out_count),
        .o_res_push   (res_push),
        .o_res_drive  (res_drive)
    );

    // Result queue: the consumer may hold off pop; once both queues fill, intake stops.
    pidc_fifo #(
        .WIDTH (ACC_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_drive),
        .o_full  (),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_drive),
        .o_count (out_count)
    );

endmodule

`default_nettype wire

// File: sim/tb_pid_positional_clamped_top.sv
// Self-checking testbench for pid_positional_clamped_top: a directed plan, then random phases.
// Each drive value is checked against a value typed in the plan or an in-bench PID predictor.
// Depends on pidc_pkg and the RTL under rtl/core only.
module tb_pid_positional_clamped_top
    import pidc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes above the last register.
    // A write to any of them must leave every gain and limit as it was.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7F_FFFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh80_0000;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sh01_0000;
    localparam logic [LIM_W-1:0]         LIM_MAX  = 31'h7FFF_FFFF;

    localparam int N_PLAN          = 42;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 140;
    // Waiting this long after the last transfer is enough for the block to be idle.
    localparam int SETTLE_CYCLES   = 8;
    // About 1700 transfers, plus the drains between phases. This limit allows
    // many times the cycles that they take.
    localparam int CYCLE_LIMIT     = 100_000;

    typedef enum logic [0:0] {ROW_WRITE, ROW_SAMPLE} t_row_kind;
    typedef enum logic [1:0] {STYLE_EXTREME, STYLE_MODEST, STYLE_WIDE} t_style;

    // One step of the directed plan. A write row uses index and data only.
    // A sample row uses target and measured. When pinned is set, the drive value is
    // typed in the row; otherwise the predictor supplies it.
    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       index;
        logic [LIM_W-1:0]           data;
        logic signed [SAMPLE_W-1:0] target;
        logic signed [SAMPLE_W-1:0] measured;
        logic                       pinned;
        logic signed [ACC_W-1:0]    drive;
    } t_plan_row;

    // Every input has a known value from time zero.
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        push        = 1'b0;
    logic signed [SAMPLE_W-1:0]  i_target    = '0;
    logic signed [SAMPLE_W-1:0]  i_measured  = '0;
    logic                        pop         = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [LIM_W-1:0]            i_cfg_wdata = '0;
    logic                        full;
    logic                        empty;
    logic signed [ACC_W-1:0]     o_drive;

    // Predictor state. It mirrors the block just after reset.
    t_cfg                        cfg_model      = '0;
    logic signed [ERR_W-1:0]     prev_err_model = '0;
    logic signed [ACC_W-1:0]     integ_model    = '0;

    // Drive values still expected, oldest first.
    logic signed [ACC_W-1:0]     drive_pending [$];
    int                          fault_count = 0;
    int                          cycle_count = 0;
    int                          send_idle_pct = 0;
    int                          pop_stall_pct = 0;

    // Idle patterns by mode: none, sender idle, receiver stalling, both.
    int send_idle_by_mode [4] = '{0, 54, 0, 35};
    int pop_stall_by_mode [4] = '{0, 0, 54, 35};

    t_plan_row plan [N_PLAN] = '{
        // All registers are zero after reset, so the zero limits force every drive to zero.
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 32'sh0000_0000},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, 32'sh0000_0000},
        '{ROW_SAMPLE, '0, '0, 16'sh5555, 16'shAAAA, 1'b1, 32'sh0000_0000},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0000, 1'b1, 32'sh0000_0000},
        // Unit proportional gain only, with the output open. The writes to the spare
        // indexes come last, so that any aliasing onto a real register would show up.
        '{ROW_WRITE, REG_GAIN_P,  31'h0001_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_I,  31'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_D,  31'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_INT_LIM, 31'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_OUT_LIM, 31'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_5, 31'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_6, 31'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_7, 31'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0001, 16'sh0000, 1'b1, 32'sh0001_0000},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0001, 1'b1, 32'shFFFF_0000},
        // The full error range cannot be shown in 32 bits, so the output limit takes over.
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 32'sh7FFF_FFFF},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, 32'sh8000_0001},
        '{ROW_SAMPLE, '0, '0, 16'sh0064, 16'sh0064, 1'b1, 32'sh0000_0000},
        // Full-scale gains with a zero output limit. The integrator still saturates.
        // The gain_i write carries junk above bit 23, which must be ignored.
        '{ROW_WRITE, REG_GAIN_P,  31'h007F_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_I,  31'h7F80_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_D,  31'h007F_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_INT_LIM, 31'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_OUT_LIM, 31'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 32'sh0000_0000},
        '{ROW_SAMPLE, '0, '0, 16'shFFFF, 16'sh0000, 1'b1, 32'sh0000_0000},
        // Output open again. A zero integral limit pulls the saturated integrator to zero.
        '{ROW_WRITE, REG_INT_LIM, 31'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_OUT_LIM, 31'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh04D2, 16'shFFFD, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0000, 1'b0, '0},
        // Mid-range settings, so that the integrator winds up slowly against its limit.
        '{ROW_WRITE, REG_GAIN_P,  31'h0000_8000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_I,  31'h0000_0400, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_D,  31'h2AFF_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_INT_LIM, 31'h0010_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, REG_OUT_LIM, 31'h0100_0000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh000A, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh000A, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'shFFFB, 16'sh0014, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh012C, 16'shFED4, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0FA0, 16'sh0F00, 1'b0, '0}
    };

    pid_positional_clamped_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_target    (i_target),
        .i_measured  (i_measured),
        .empty       (empty),
        .pop         (pop),
        .o_drive     (o_drive),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Symmetric saturation of an exact 64-bit value to plus or minus the limit.
    function automatic longint limit_to(input longint x, input logic [LIM_W-1:0] lim);
        longint bound;
        bound = longint'(lim);
        if (x > bound) begin
            return bound;
        end else if (x < -bound) begin
            return -bound;
        end
        return x;
    endfunction

    // Advances the predictor by one sample and returns the drive value it should give.
    // All products and sums are exact in 64 bits; only the two clamps narrow them.
    function automatic logic signed [ACC_W-1:0] next_drive(
        input logic signed [SAMPLE_W-1:0] tgt,
        input logic signed [SAMPLE_W-1:0] meas
    );
        longint err;
        longint p_term;
        longint d_term;
        longint total;
        err    = longint'(tgt) - longint'(meas);
        p_term = longint'($signed(cfg_model.gain_p)) * err;
        d_term = longint'($signed(cfg_model.gain_d)) * (err - longint'(prev_err_model));
        integ_model = ACC_W'(limit_to(longint'(integ_model)
                              + longint'($signed(cfg_model.gain_i)) * err,
                              cfg_model.integral_limit));
        prev_err_model = ERR_W'(err);
        total = limit_to(p_term + longint'(integ_model) + d_term, cfg_model.output_limit);
        return total[ACC_W-1:0];
    endfunction

    task automatic report_fault(input string msg);
        $display("[%0t] drive check: %s", $time, msg);
        fault_count++;
    endtask

    // Writes one register at the next edge and mirrors the write in the predictor.
    // The write enable is left high, so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_GAIN_P:  cfg_model.gain_p         = data[GAIN_W-1:0];
            REG_GAIN_I:  cfg_model.gain_i         = data[GAIN_W-1:0];
            REG_GAIN_D:  cfg_model.gain_d         = data[GAIN_W-1:0];
            REG_INT_LIM: cfg_model.integral_limit = data;
            REG_OUT_LIM: cfg_model.output_limit   = data;
            default: ;
        endcase
    endtask

    // Offers one sample after a random idle gap and waits for its transfer.
    // Push is left high afterwards, so that a following sample can go straight on.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] tgt,
        input logic signed [SAMPLE_W-1:0] meas,
        input logic                       use_pinned,
        input logic signed [ACC_W-1:0]    pinned_drive
    );
        logic signed [ACC_W-1:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_target   <= tgt;
        i_measured <= meas;
        do @(posedge i_clk); while (full);
        // The transfer took place at this edge. The predictor still runs for a pinned row,
        // so that its state stays in step with the block.
        predicted = next_drive(tgt, meas);
        drive_pending.push_back(use_pinned ? pinned_drive : predicted);
    endtask

    // Stops offering samples and waits until every drive value has arrived,
    // then gives the pipeline a few more edges to go quiet.
    task automatic drain_block();
        push <= 1'b0;
        while (drive_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Gain data carries random junk above bit 23, which the block must ignore.
    function automatic logic [LIM_W-1:0] pick_gain(input t_style style);
        logic [31:0]              pad;
        logic signed [GAIN_W-1:0] g;
        pad = $urandom;
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(3))
                    0:       g = GAIN_MAX;
                    1:       g = GAIN_MIN;
                    2:       g = '0;
                    default: g = GAIN_ONE;
                endcase
            end
            STYLE_MODEST: g = GAIN_W'(int'($urandom_range(8192)) - 4096);
            default:      g = GAIN_W'($urandom);
        endcase
        return {pad[LIM_W-GAIN_W-1:0], g};
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit(input t_style style);
        logic [LIM_W-1:0] lim;
        case (style)
            STYLE_EXTREME: begin
                case ($urandom_range(2))
                    0:       lim = '0;
                    1:       lim = LIM_MAX;
                    default: lim = LIM_W'($urandom);
                endcase
            end
            STYLE_MODEST: lim = LIM_W'($urandom) >> $urandom_range(10);
            default:      lim = LIM_W'($urandom);
        endcase
        return lim;
    endfunction

    // Result side. A drive value transfers at an edge where pop is high and empty is low.
    // Both are sampled before the edge's own updates land, so this is free of races.
    always @(posedge i_clk) begin : result_side
        logic signed [ACC_W-1:0] want;
        if (i_rst_n && pop && !empty) begin
            if (drive_pending.size() == 0) begin
                report_fault($sformatf("drive %0d arrived with nothing pending", o_drive));
            end else begin
                want = drive_pending.pop_front();
                if (o_drive !== want) begin
                    report_fault($sformatf("drive expected %0d got %0d", want, o_drive));
                end
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[pid_positional_clamped_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic                       writing;
        logic signed [SAMPLE_W-1:0] tgt;
        logic signed [SAMPLE_W-1:0] meas;
        int                         near;
        t_style                     style;

        writing = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed plan. It runs with no idling. Registers change only once the block has
        // drained, so that no sample in flight sees a half-written setting.
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                if (!writing) begin
                    drain_block();
                end
                write_reg(plan[r].index, plan[r].data);
                writing = 1'b1;
            end else begin
                if (writing) begin
                    i_cfg_wr_en <= 1'b0;
                end
                writing = 1'b0;
                send_sample(plan[r].target, plan[r].measured, plan[r].pinned, plan[r].drive);
            end
        end

        // Random phases. The idle pattern and the style of settings step through their
        // choices at different rates, so that each pattern meets more than one style.
        for (int p = 0; p < N_PHASES; p++) begin
            drain_block();
            send_idle_pct = send_idle_by_mode[p % 4];
            pop_stall_pct = pop_stall_by_mode[p % 4];
            style = t_style'(p % 3);
            write_reg(REG_GAIN_P,  pick_gain(style));
            write_reg(REG_GAIN_I,  pick_gain(style));
            write_reg(REG_GAIN_D,  pick_gain(style));
            write_reg(REG_INT_LIM, pick_limit(style));
            write_reg(REG_OUT_LIM, pick_limit(style));
            write_reg(REG_SPARE_5, LIM_W'($urandom));
            write_reg(REG_SPARE_6, LIM_W'($urandom));
            write_reg(REG_SPARE_7, LIM_W'($urandom));
            i_cfg_wr_en <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                tgt = SAMPLE_W'($urandom);
                // Mostly a loop that tracks its target closely, so that errors stay small
                // and the clamps are often left alone. The rest are full-range jumps.
                if ($urandom_range(99) < 60) begin
                    near = int'(tgt) + int'($urandom_range(128)) - 64;
                    if (near > 32767) begin
                        near = 32767;
                    end else if (near < -32768) begin
                        near = -32768;
                    end
                    meas = near[SAMPLE_W-1:0];
                end else begin
                    meas = SAMPLE_W'($urandom);
                end
                send_sample(tgt, meas, 1'b0, '0);
            end
        end

        drain_block();
        if (fault_count == 0) begin
            $display("[pid_positional_clamped_top] OK");
        end else begin
            $display("[pid_positional_clamped_top] ERROR");
        end
        $finish;
    end

endmodule
